// ----- rtl/core/mcbd_pkg.sv -----
// Shared constants for the mipmap chain box downsampler.
// No dependencies; used by mcbd_avg_unit and mipmap_chain_box_downsample.
`default_nettype none

package mcbd_pkg;

  // Field widths
  localparam int unsigned PIX_W    = 32;  // RGBA8 pixel
  localparam int unsigned CHAN_N   = 4;   // channels per pixel
  localparam int unsigned CHAN_W   = 8;   // bits per channel
  localparam int unsigned PSUM_W   = 9;   // one channel pair sum
  localparam int unsigned QSUM_W   = 10;  // one channel quad sum plus rounding
  localparam int unsigned HSUM_W   = CHAN_N * PSUM_W;  // packed pair sums
  localparam int unsigned USUM_W   = CHAN_N * QSUM_W;  // packed unit results
  localparam int unsigned LOG2_W   = 4;   // size registers and level number
  localparam int unsigned POS_W    = 10;  // column and row ports
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Register map, selected by paddr[2]
  localparam logic REG_WIDTH_LOG2  = 1'b0;
  localparam logic REG_HEIGHT_LOG2 = 1'b1;

  // Reset values of the size registers
  localparam logic [LOG2_W-1:0] WIDTH_LOG2_RST  = 4'd8;
  localparam logic [LOG2_W-1:0] HEIGHT_LOG2_RST = 4'd8;

  // Rounding term of the 2x2 average: (sum + 2) >> 2
  localparam logic [QSUM_W-1:0] QUAD_ROUND = 10'd2;

endpackage : mcbd_pkg

`default_nettype wire

// ----- rtl/core/mcbd_avg_unit.sv -----
// Shared per-channel adder used by every level of the cascade.
// Depends on mcbd_pkg for lane widths and the rounding constant.
`default_nettype none

module mcbd_avg_unit (
  input  wire logic [mcbd_pkg::HSUM_W-1:0] a_i,      // four 9-bit lanes
  input  wire logic [mcbd_pkg::HSUM_W-1:0] b_i,      // four 9-bit lanes
  input  wire logic                        round_i,  // add the quad rounding term
  output logic      [mcbd_pkg::USUM_W-1:0] sum_o     // four 10-bit lanes
);

  logic [mcbd_pkg::QSUM_W-1:0] rnd;

  assign rnd = round_i ? mcbd_pkg::QUAD_ROUND : '0;

  // One adder per channel lane
  always_comb begin
    for (int i = 0; i < mcbd_pkg::CHAN_N; i++) begin
      sum_o[i*mcbd_pkg::QSUM_W +: mcbd_pkg::QSUM_W] =
        mcbd_pkg::QSUM_W'(a_i[i*mcbd_pkg::PSUM_W +: mcbd_pkg::PSUM_W]) +
        mcbd_pkg::QSUM_W'(b_i[i*mcbd_pkg::PSUM_W +: mcbd_pkg::PSUM_W]) + rnd;
    end
  end

endmodule : mcbd_avg_unit

`default_nettype wire

// ----- rtl/core/mipmap_chain_box_downsample.sv -----
// Top level of the streaming mipmap chain builder: sequencer, level counters,
// pair and row-sum stores, APB registers. Depends on mcbd_pkg and mcbd_avg_unit.
`default_nettype none

// Level-0 RGBA8 pixels enter in raster order, one item per handshake. Each item
// yields itself as a level-0 result and then every lower-level pixel it
// completes, down to 1x1; last_of_run_o marks the final result of an item.
// One shared four-lane adder does all averaging under a small sequencer: each
// accepted item takes an emit step per result, and every 2x2 average adds a
// quad step, which waits on the registered read of the row-sum memory; an emit
// step waits while the output register holds a stalled result.
// The input stays stalled until
// the last result of an item sits in the output register. Image sides are
// 2**width_log2 by 2**height_log2 (APB offsets 0x0 and 0x4); a register write
// restarts the frame at pixel (0,0). Write the registers only while the block
// is idle. The row-sum memory needs no clearing pass.
module mipmap_chain_box_downsample #(
  parameter int unsigned MAX_LOG2_WIDTH  = 10,
  parameter int unsigned MAX_LOG2_HEIGHT = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcbd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [mcbd_pkg::APB_DW-1:0]   pwdata,
  output logic      [mcbd_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  // input pixels
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mcbd_pkg::PIX_W-1:0]    pixel_in_i,
  // result pixels
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [mcbd_pkg::LOG2_W-1:0]   level_o,
  output logic      [mcbd_pkg::POS_W-1:0]    column_o,
  output logic      [mcbd_pkg::POS_W-1:0]    row_o,
  output logic      [mcbd_pkg::PIX_W-1:0]    pixel_out_o,
  output logic                               last_of_run_o
);

  localparam int unsigned NL = (MAX_LOG2_WIDTH > MAX_LOG2_HEIGHT) ?
                               MAX_LOG2_WIDTH : MAX_LOG2_HEIGHT;  // levels below 0
  localparam int unsigned IW = (NL > 1) ? $clog2(NL) : 1;
  localparam int unsigned CW = MAX_LOG2_WIDTH;
  localparam int unsigned RW = MAX_LOG2_HEIGHT;
  localparam int unsigned AW = MAX_LOG2_WIDTH;
  localparam int unsigned RB = (1 << MAX_LOG2_WIDTH) - 1;  // row-sum entries

  localparam int unsigned LW = mcbd_pkg::LOG2_W;
  localparam int unsigned CN = mcbd_pkg::CHAN_N;
  localparam int unsigned CB = mcbd_pkg::CHAN_W;
  localparam int unsigned PS = mcbd_pkg::PSUM_W;
  localparam int unsigned QS = mcbd_pkg::QSUM_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_QUAD = 2'd2;

  // Low-bit mask of a level side, 2**lw - 1
  function automatic logic [CW-1:0] col_mask(input logic [LW-1:0] lw);
    logic [CW:0] m;
    m = ((CW+1)'(1) << lw) - (CW+1)'(1);
    return m[CW-1:0];
  endfunction

  function automatic logic [RW-1:0] row_mask(input logic [LW-1:0] lh);
    logic [RW:0] m;
    m = ((RW+1)'(1) << lh) - (RW+1)'(1);
    return m[RW-1:0];
  endfunction

  function automatic logic [LW-1:0] sat_sub(input logic [LW-1:0] a,
                                            input logic [LW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // Spread the bytes of a pixel into 9-bit lanes
  function automatic logic [mcbd_pkg::HSUM_W-1:0] to_lanes(
      input logic [mcbd_pkg::PIX_W-1:0] px);
    logic [mcbd_pkg::HSUM_W-1:0] l;
    for (int i = 0; i < CN; i++) begin
      l[i*PS +: PS] = PS'(px[i*CB +: CB]);
    end
    return l;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  logic [1:0]                       state_q, state_d;
  logic [LW-1:0]                    width_log2_q, height_log2_q;
  logic [CW-1:0]                    in_col_q;
  logic [RW-1:0]                    in_row_q;
  logic [CW-1:0]                    lvl_col_q [NL];
  logic [RW-1:0]                    lvl_row_q [NL];
  logic [mcbd_pkg::PIX_W-1:0]       hold_q [NL];
  logic [mcbd_pkg::HSUM_W-1:0]      row_mem [RB];
  logic [mcbd_pkg::HSUM_W-1:0]      rd_q;
  logic [mcbd_pkg::HSUM_W-1:0]      hs_q;
  logic [LW-1:0]                    k_q;
  logic [CW-1:0]                    c_q;
  logic [RW-1:0]                    r_q;
  logic [mcbd_pkg::PIX_W-1:0]       p_q;
  logic                             out_valid_q;
  logic [LW-1:0]                    out_level_q;
  logic [CW-1:0]                    out_col_q;
  logic [RW-1:0]                    out_row_q;
  logic [mcbd_pkg::PIX_W-1:0]       out_pix_q;
  logic                             out_last_q;

  // ---------------------------------------------------------------------------
  // APB registers
  logic cfg_wr;
  logic cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_sel)
      mcbd_pkg::REG_WIDTH_LOG2:  prdata = mcbd_pkg::APB_DW'(width_log2_q);
      mcbd_pkg::REG_HEIGHT_LOG2: prdata = mcbd_pkg::APB_DW'(height_log2_q);
      default:                   prdata = '0;
    endcase
  end

  // Sizes in use, clamped to what the stores hold
  logic [LW-1:0] wl, hl, top;

  assign wl  = (width_log2_q  > LW'(MAX_LOG2_WIDTH))  ? LW'(MAX_LOG2_WIDTH)  : width_log2_q;
  assign hl  = (height_log2_q > LW'(MAX_LOG2_HEIGHT)) ? LW'(MAX_LOG2_HEIGHT) : height_log2_q;
  assign top = (wl > hl) ? wl : hl;

  // ---------------------------------------------------------------------------
  // Step decode for the current level k
  logic           accept;
  logic           slot_free;
  logic           emit_go;
  logic [LW-1:0]  lw_k, lh_k, lw_n, lh_n;
  logic           step_ok;
  logic           both_big;
  logic           pair_odd;
  logic           step_ready;
  logic           emit_last;
  logic [IW-1:0]  ki;

  assign accept    = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit_go   = (state_q == S_EMIT) && slot_free;

  assign ki       = k_q[IW-1:0];
  assign lw_k     = sat_sub(wl, k_q);
  assign lh_k     = sat_sub(hl, k_q);
  assign lw_n     = sat_sub(wl, k_q + LW'(1));
  assign lh_n     = sat_sub(hl, k_q + LW'(1));
  assign step_ok  = (k_q < top);
  assign both_big = (lw_k != '0) && (lh_k != '0);

  // Second pixel of a pair along the side that still halves
  always_comb begin
    if (both_big) begin
      pair_odd   = c_q[0];
      step_ready = c_q[0] && r_q[0];
    end else if (lw_k != '0) begin
      pair_odd   = c_q[0];
      step_ready = c_q[0];
    end else begin
      pair_odd   = r_q[0];
      step_ready = r_q[0];
    end
  end

  assign emit_last = !(step_ok && step_ready);

  // Row-sum address: region of level k plus the pair column
  logic [AW:0]   full_w, sub_w, idx_w;
  logic [AW-1:0] row_addr;

  assign full_w   = (AW+1)'(1) << wl;
  assign sub_w    = full_w >> k_q;
  assign idx_w    = full_w - sub_w + (AW+1)'(c_q >> 1);
  assign row_addr = idx_w[AW-1:0];

  // ---------------------------------------------------------------------------
  // Shared channel adder
  logic [mcbd_pkg::HSUM_W-1:0] op_a, op_b;
  logic                        op_round;
  logic [mcbd_pkg::USUM_W-1:0] usum;

  always_comb begin
    if (state_q == S_QUAD) begin
      op_a     = rd_q;
      op_b     = hs_q;
      op_round = 1'b1;
    end else begin
      op_a     = to_lanes(hold_q[ki]);
      op_b     = to_lanes(p_q);
      op_round = 1'b0;
    end
  end

  mcbd_avg_unit u_avg (
    .a_i     (op_a),
    .b_i     (op_b),
    .round_i (op_round),
    .sum_o   (usum)
  );

  // Repack the lane sums
  logic [mcbd_pkg::HSUM_W-1:0] hs;
  logic [mcbd_pkg::PIX_W-1:0]  half_pix, quad_pix;

  always_comb begin
    for (int i = 0; i < CN; i++) begin
      hs[i*PS +: PS]       = usum[i*QS +: PS];
      half_pix[i*CB +: CB] = usum[i*QS + 1 +: CB];
      quad_pix[i*CB +: CB] = usum[i*QS + 2 +: CB];
    end
  end

  // ---------------------------------------------------------------------------
  // Step actions
  logic                       hold_we, mem_we, mem_re;
  logic                       go_down;     // a pixel of level k+1 is ready
  logic [mcbd_pkg::PIX_W-1:0] down_pix;

  always_comb begin
    hold_we  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    go_down  = 1'b0;
    down_pix = half_pix;
    state_d  = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          if (step_ok) begin
            if (!pair_odd) begin
              hold_we = 1'b1;
            end else if (both_big) begin
              mem_we = !r_q[0];
              mem_re = r_q[0];
            end else begin
              go_down = 1'b1;
            end
          end
          if (emit_last)   state_d = S_IDLE;
          else if (mem_re) state_d = S_QUAD;
        end
      end
      S_QUAD: begin
        go_down  = 1'b1;
        down_pix = quad_pix;
        state_d  = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Next position at level k+1
  logic [CW-1:0] lvl_col_nx;
  logic [RW-1:0] lvl_row_nx;
  logic          lvl_col_wrap;

  assign lvl_col_wrap = (lvl_col_q[ki] == col_mask(lw_n));

  always_comb begin
    lvl_col_nx = lvl_col_wrap ? '0 : lvl_col_q[ki] + CW'(1);
    lvl_row_nx = lvl_row_q[ki];
    if (lvl_col_wrap) begin
      lvl_row_nx = (lvl_row_q[ki] == row_mask(lh_n)) ? '0 : lvl_row_q[ki] + RW'(1);
    end
  end

  // Next level-0 position
  logic [CW-1:0] in_col_nx;
  logic [RW-1:0] in_row_nx;
  logic          in_col_wrap;

  assign in_col_wrap = (in_col_q == col_mask(wl));

  always_comb begin
    in_col_nx = in_col_wrap ? '0 : in_col_q + CW'(1);
    in_row_nx = in_row_q;
    if (in_col_wrap) begin
      in_row_nx = (in_row_q == row_mask(hl)) ? '0 : in_row_q + RW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Control state and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      width_log2_q  <= mcbd_pkg::WIDTH_LOG2_RST;
      height_log2_q <= mcbd_pkg::HEIGHT_LOG2_RST;
      in_col_q      <= '0;
      in_row_q      <= '0;
      k_q           <= '0;
      for (int i = 0; i < NL; i++) begin
        lvl_col_q[i] <= '0;
        lvl_row_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (cfg_sel)
          mcbd_pkg::REG_WIDTH_LOG2:  width_log2_q  <= pwdata[LW-1:0];
          mcbd_pkg::REG_HEIGHT_LOG2: height_log2_q <= pwdata[LW-1:0];
          default: ;
        endcase
        in_col_q <= '0;
        in_row_q <= '0;
        for (int i = 0; i < NL; i++) begin
          lvl_col_q[i] <= '0;
          lvl_row_q[i] <= '0;
        end
      end else begin
        if (accept) begin
          in_col_q <= in_col_nx;
          in_row_q <= in_row_nx;
          k_q      <= '0;
        end
        if (go_down) begin
          lvl_col_q[ki] <= lvl_col_nx;
          lvl_row_q[ki] <= lvl_row_nx;
          k_q           <= k_q + LW'(1);
        end
      end
    end
  end

  // Current item: pixel and position at level k
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= pixel_in_i;
      c_q <= in_col_q;
      r_q <= in_row_q;
    end else if (go_down) begin
      p_q <= down_pix;
      c_q <= lvl_col_q[ki];
      r_q <= lvl_row_q[ki];
    end
  end

  // Pair hold and row-sum memory
  always_ff @(posedge clk_i) begin
    if (hold_we) hold_q[ki] <= p_q;
    if (mem_we)  row_mem[row_addr] <= hs;
    if (mem_re) begin
      rd_q <= row_mem[row_addr];
      hs_q <= hs;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_level_q <= k_q;
      out_col_q   <= c_q;
      out_row_q   <= r_q;
      out_pix_q   <= p_q;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_o       = out_level_q;
  assign column_o      = mcbd_pkg::POS_W'(out_col_q);
  assign row_o         = mcbd_pkg::POS_W'(out_row_q);
  assign pixel_out_o   = out_pix_q;
  assign last_of_run_o = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
`ifndef SYNTHESIS
  // A 2x2 average is only fetched for a level that still has a lower one
  a_quad_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QUAD) |-> (k_q < top))
    else $error("row-sum fetch beyond the last level");

  // Results never name a level below 1x1
  a_out_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o <= top))
    else $error("result level out of range");

  // The input side only closes after it took an item
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stalled without an accepted item");

  // Leaving the 2x2 average step returns to the emit state with k advanced by one level
  a_quad_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QUAD) |=> (state_q == S_EMIT) && (k_q == $past(k_q) + LW'(1)))
    else $error("2x2 average did not advance the level");
`endif

endmodule : mipmap_chain_box_downsample

`default_nettype wire
